### src/sha_pkg.sv
// Shared constants and functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   localparam int ByteCount = 64;
   localparam int LenPos    = 56;

   typedef logic [31:0] word_type;

   function automatic word_type round_const(input logic [5:0] idx);
      word_type k;
      begin
         unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
         endcase
         return k;
      end
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h;
      begin
         unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
         endcase
         return h;
      end
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

### src/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer and digest output.
//
// Input beats carry one message byte with has_byte and last_byte flags. A byte
// that does not fill the block is written straight into the block store. The
// 64th byte of a block starts a compression: the shared round unit runs one
// round a cycle, and the steps load, fetch, 64 rounds and add follow, during
// which req_tready is low. A beat with last_byte pads the block byte by byte,
// compresses once, or twice when 56 or more bytes are pending or its byte
// completes the block, then presents eight digest words on the result channel,
// one per beat, index 0 first. A stalled receiver holds the current word; no
// new input is taken until all eight words have left. After the last word the
// chain returns to the initial values. Reset clears the sequencer, fill count
// and bit count and loads the initial chain; the block store needs no clearing,
// as padding overwrites every byte that a compression reads.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // has_byte
   input  wire logic        req_tlast,   // last_byte
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output      logic        rsp_tlast    // last_word
);
   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StPad   = 4'd1;  // write padding bytes
   localparam logic [3:0] StLen   = 4'd2;  // write length bytes
   localparam logic [3:0] StLoad  = 4'd3;
   localparam logic [3:0] StRound = 4'd4;
   localparam logic [3:0] StAdd   = 4'd5;
   localparam logic [3:0] StOut   = 4'd6;
   localparam logic [3:0] StFetch = 4'd7;  // first block word read

   logic [3:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  cnt_ff, cnt_in;      // round, pad position or output index
   logic        final_ff, final_in;  // compression belongs to the finish
   logic        second_ff, second_in;// another padding block still follows
   word_type    chain_ff [8];
   word_type    work [8];
   logic [31:0] store [16];
   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   word_type    rd_word_ff;
   logic [3:0]  rd_idx;
   logic        take;

   assign take = req_tvalid && req_tready;
   assign req_tready = (state_ff == StIdle);

   // Block store: byte writes, one 32-bit big-endian word read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
      rd_word_ff <= store[rd_idx];
   end

   always_comb begin
      // Word needed by round cnt+1 is read during round cnt, so it is registered when that round runs.
      rd_idx = (state_ff == StRound) ? (cnt_ff[3:0] + 4'd1) : 4'd0;
   end

   sha_round u_round (
      .clock(clock), .reset(reset),
      .load(state_ff == StLoad), .step(state_ff == StRound),
      .round(cnt_ff), .sched_in(rd_word_ff),
      .chain_in(chain_ff), .work_out(work)
   );

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; bits_in = bits_ff; cnt_in = cnt_ff;
      final_in = final_ff; second_in = second_ff;
      wr_en = 1'b0; wr_addr = fill_ff; wr_data = req_tdata;
      unique case (state_ff)
         StIdle: begin
            if (take) begin
               if (req_tuser) begin
                  wr_en = 1'b1;
                  bits_in = bits_ff + 64'd8;
                  fill_in = fill_ff + 6'd1;
               end
               final_in = req_tlast;
               if (req_tuser && fill_ff == 6'd63) begin
                  // A beat that completes the block starts a compression; a finishing one then pads a fresh block.
                  state_in = StLoad; second_in = req_tlast;
               end else if (req_tlast) begin
                  state_in = StPad;
                  cnt_in = req_tuser ? fill_ff + 6'd1 : fill_ff;
                  second_in = 1'b0;
               end
            end
         end
         StPad: begin
            // 0x80 at the fill position unless second_ff, zeros up to the length field or block end.
            wr_en = 1'b1; wr_addr = cnt_ff;
            wr_data = (cnt_ff == fill_ff) && !second_ff ? 8'h80 : 8'h00;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = StLoad; second_in = 1'b1;
            end else if (cnt_ff == 6'(LenPos - 1) && !((fill_ff >= 6'(LenPos)) && !second_ff))
            begin
               state_in = StLen;
            end
         end
         StLen: begin
            wr_en = 1'b1; wr_addr = cnt_ff;
            wr_data = bits_ff[8'(7 - cnt_ff[2:0]) * 8 +: 8];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = StLoad; second_in = 1'b0;
            end
         end
         StLoad: begin
            cnt_in = '0; state_in = StFetch;
         end
         StFetch: state_in = StRound;
         StRound: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = StAdd;
         end
         StAdd: begin
            fill_in = '0;
            if (!final_ff) state_in = StIdle;
            else if (second_ff) begin
               // The marker byte is still missing when the data filled the block.
               state_in = StPad; cnt_in = '0; second_in = (fill_ff != 6'd0);
            end else begin
               state_in = StOut; cnt_in = '0;
            end
         end
         StOut: begin
            if (rsp_tready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  state_in = StIdle; bits_in = '0; fill_in = '0; final_in = 1'b0;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle; fill_ff <= '0; bits_ff <= '0; cnt_ff <= '0;
         final_ff <= 1'b0; second_ff <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in; fill_ff <= fill_in; bits_ff <= bits_in;
         cnt_ff <= cnt_in; final_ff <= final_in; second_ff <= second_in;
         if (state_ff == StAdd) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work[i];
         end else if (state_ff == StOut && rsp_tready && cnt_ff[2:0] == 3'd7) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= init_hash(3'(i));
         end
      end
   end

   assign rsp_tvalid = (state_ff == StOut);
   assign rsp_tdata  = {5'd0, cnt_ff[2:0], chain_ff[cnt_ff[2:0]]};
   assign rsp_tlast  = (cnt_ff[2:0] == 3'd7);

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> !req_tready) else $error("ready while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped under stall");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRound && cnt_ff == 6'd63) |=> (state_ff == StAdd))
      else $error("round count slip");
endmodule
`default_nettype wire

### src/sha_round.sv
// One SHA-256 round with the rolling schedule, stepped once a cycle by the top level.
`timescale 1ns / 1ps
`default_nettype none
module sha_round
   import sha_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,       // take working words from the chain
   input  wire logic         step,       // run one round
   input  wire logic [5:0]   round,
   input  wire word_type     sched_in,   // block word for rounds below 16
   input  wire word_type     chain_in [8],
   output      word_type     work_out [8]
);
   word_type v_ff [8];
   word_type w_ff [16];
   word_type w_cur, s0, s1, t1, t2, w15, w2;

   always_comb begin
      w15 = w_ff[1];
      w2  = w_ff[14];
      s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
      s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
      // The window shifts each round, so index 0 is always w[r-16].
      w_cur = (round < 6'd16) ? sched_in : (w_ff[0] + s0 + w_ff[9] + s1);
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_const(round) + w_cur;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= '0;
      end else if (load) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_in[i];
      end else if (step) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
      end
   end

   assign work_out = v_ff;
endmodule
`default_nettype wire

### sim/sha256_digest_checker.sv
// Digest checker: watches both channels, hashes accepted bytes and compares digest words.
`timescale 1ns / 1ps
`default_nettype none
module sha256_digest_checker
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               words_pending
);

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] StartHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]  chain [8];
   logic [63:0]  bit_total;
   logic [7:0]   pending_bytes [64];
   int           pending_fill;
   digest_beat_type digest_queue [$];

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic mix_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int j = 0; j < 16; j++)
         w[j] = {pending_bytes[4*j], pending_bytes[4*j+1], pending_bytes[4*j+2],
                 pending_bytes[4*j+3]};
      for (int j = 16; j < 64; j++)
         w[j] = w[j-16] + (ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3))
              + w[j-7] + (ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10));
      for (int j = 0; j < 8; j++) v[j] = chain[j];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] += v[j];
   endtask

   task automatic restart_message();
      for (int j = 0; j < 8; j++) chain[j] = StartHash[j];
      bit_total    = '0;
      pending_fill = 0;
   endtask

   task automatic take_beat(input logic [7:0] data, input logic has, input logic fin);
      digest_beat_type b;
      if (has) begin
         pending_bytes[pending_fill] = data;
         bit_total += 64'd8;
         pending_fill++;
         if (pending_fill == 64) begin
            mix_block();
            pending_fill = 0;
         end
      end
      if (fin) begin
         pending_bytes[pending_fill] = 8'h80;
         for (int j = pending_fill + 1; j < 64; j++) pending_bytes[j] = 8'h00;
         // Length no longer fits behind the marker byte, so one extra block.
         if (pending_fill >= LenPos) begin
            mix_block();
            for (int j = 0; j < LenPos; j++) pending_bytes[j] = 8'h00;
         end
         for (int j = 0; j < 8; j++) pending_bytes[LenPos + j] = bit_total[63 - 8*j -: 8];
         mix_block();
         for (int j = 0; j < 8; j++) begin
            b.digest_word = chain[j];
            b.word_index  = 3'(j);
            b.last_word   = (j == 7);
            digest_queue.push_back(b);
         end
         restart_message();
      end
   endtask

   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         restart_message();
         digest_queue.delete();
         fail_count    <= 0;
      end else begin
         if (req_tvalid && req_tready) take_beat(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest beat: expected none, actual %h %0d %b",
                        $time, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_tdata[31:0] !== want.digest_word ||
                   rsp_tdata[34:32] !== want.word_index ||
                   rsp_tlast !== want.last_word || rsp_tdata[39:35] !== 5'd0) begin
                  $display("%0t: digest beat mismatch: expected %h %0d %b, actual %h %0d %b",
                           $time, want.digest_word, want.word_index, want.last_word,
                           rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      words_pending <= digest_queue.size();
   end

endmodule
`default_nettype wire

### sim/sha256_stream_hasher_test.sv
// Testbench top: drives byte beats into the hasher, throttles the digest side, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          words_pending;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   bit          sending_done = 1'b0;
   bit          hold_off = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sha256_stream_hasher u_top (.*);
   sha256_digest_checker u_chk (.*);

   // One beat; random gaps in front of it unless the run has gone calm.
   task automatic send_beat(input logic [7:0] data, input logic has, input logic fin);
      int gap;
      bit ready_seen;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= fin;
      // Ready is sampled mid-cycle, so it is the value seen by the next edge.
      forever begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
         if (ready_seen) break;
      end
   endtask

   task automatic send_message(input int len, input bit end_alone);
      for (int i = 0; i < len; i++)
         send_beat(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
      if (end_alone || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty message, quiet beats, byte extremes, 55/56/63/64-byte ends.
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hff, 1'b1, 1'b0);
      send_beat(8'h5a, 1'b0, 1'b0);
      send_beat(8'ha5, 1'b1, 1'b1);
      send_message(55, 1'b0);
      send_message(56, 1'b0);
      send_message(63, 1'b1);
      send_message(64, 1'b1);
      send_message(64, 1'b0);
      // Long receiver hold-off while the sender keeps offering messages.
      hold_off <= 1'b1;
      send_message(3, 1'b0);
      send_message(5, 1'b0);
      send_message(2, 1'b1);
      for (int m = 0; m < 16; m++) begin
         if (m == 12) calm = 1'b1;
         case ($urandom_range(0, 7))
            0: len = $urandom_range(50, 130);
            1: len = 0;
            default: len = $urandom_range(1, 10);
         endcase
         if ($urandom_range(0, 5) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
         send_message(len, $urandom_range(0, 1));
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      int span;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 12);
            repeat (span) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      wait (sending_done);
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && !rsp_tvalid) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire
